[sv/rrt_pkg.sv]
// shared types and constants for the tree extend unit
package rrt_pkg;

    localparam int CW         = 10;
    localparam int QW         = CW + 2;
    localparam int SQ_RAD_W   = 2 * CW + 2;
    localparam int SQ_ROOT_W  = CW + 1;
    localparam int SQ_REM_W   = CW + 4;
    localparam int SQ_STAGES  = SQ_RAD_W / 2;
    localparam int PROD_W     = 2 * CW;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_OBS_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_RAD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP   = 3'd7;

    localparam logic OP_ROOT   = 1'b0;
    localparam logic OP_EXTEND = 1'b1;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_ROOT    = 3'd4;

    typedef struct packed {
        logic          opcode;
        logic [CW-1:0] point_col;
        logic [CW-1:0] point_row;
    } t_in;

    typedef struct packed {
        logic [2:0]    status;
        logic [CW-1:0] node_index;
        logic [CW-1:0] new_col;
        logic [CW-1:0] new_row;
        logic [CW-1:0] parent_index;
        logic          reached_goal;
    } t_out;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_RAD_W-1:0]  rad;
    } t_sq_data;

endpackage

[sv/rrt_tree_extend_unit.sv]
// top level of the tree extend unit
// A root transaction stores the point as node 0 without any scan. An extend makes one
// ram read per stored node to stream squared distances through the 11-cell square root
// chain, runs a 20-step bit serial divide for steering when the sample lies beyond
// max_step, then makes a second ram pass for the duplicate check.
// Items are processed one at a time; the next is taken once the result is in the
// output register.
module rrt_tree_extend_unit import rrt_pkg::*; #(
    parameter int MAX_NODES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SCAN, S_SCAN_WAIT, S_FETCH, S_STEER, S_DIV,
        S_DUP, S_DUP_WAIT, S_CHECK, S_DONE
    } t_state;

    t_state           r_state;
    logic             r_op;
    logic [CW-1:0]    r_pc, r_pr;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_addr;
    logic             r_iss_vld, r_iss_last;
    logic [IDX_W-1:0] r_iss_idx;
    logic             r_c_vld, r_c_last;
    logic [IDX_W-1:0] r_c_idx;
    t_sq_data         r_c_data;
    logic [SQ_ROOT_W-1:0] r_best;
    logic [IDX_W-1:0] r_near;
    logic [CW-1:0]    r_mc, r_mr, r_nc, r_nr;
    logic             r_dup;
    logic             r_div_go;
    t_out             r_res;
    t_out             r_out;
    logic             r_out_vld;
    logic [CW-1:0]    r_obs_l, r_obs_t, r_obs_r, r_obs_b;
    logic [CW-1:0]    r_goal_c, r_goal_r, r_goal_rad, r_max_step;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [2*CW-1:0]        ram_wdata, ram_rdata;
    logic [CW-1:0]          rd_col, rd_row;
    logic signed [CW:0]     dc, dr;
    logic [SQ_RAD_W-1:0]    sqc, sqr;
    logic                   iss_last;
    logic                   vld_ch  [SQ_STAGES+1];
    logic                   last_ch [SQ_STAGES+1];
    logic [IDX_W-1:0]       idx_ch  [SQ_STAGES+1];
    t_sq_data               data_ch [SQ_STAGES+1];
    logic [CW-1:0]          magc, magr;
    logic                   div_done_c, div_done_r;
    logic signed [QW-1:0]   quo_c, quo_r;
    logic [QW-1:0]          nc_sum, nr_sum;
    logic                   in_box, sweep, legal, full;
    logic                   goal_hit;
    logic signed [QW-1:0]   g_lo_c, g_hi_c, g_lo_r, g_hi_r, sc, sr;

    function automatic logic f_span(logic [CW-1:0] a_from, logic [CW-1:0] a_to,
                                    logic [CW-1:0] a_lo, logic [CW-1:0] a_hi);
        logic [CW:0] a, b;
        if (a_from == a_to || a_lo > a_hi) begin
            return 1'b0;
        end
        if (a_to > a_from) begin
            a = {1'b0, a_from};
            b = {1'b0, a_to} - 1'b1;
        end else begin
            a = {1'b0, a_to} + 1'b1;
            b = {1'b0, a_from};
        end
        return (a <= {1'b0, a_hi}) && (b >= {1'b0, a_lo});
    endfunction

    rrt_ram #(.W(2 * CW), .DEPTH(MAX_NODES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign vld_ch[0]  = r_c_vld;
    assign last_ch[0] = r_c_last;
    assign idx_ch[0]  = r_c_idx;
    assign data_ch[0] = r_c_data;

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_chain
        rrt_sqrt_cell #(.IDX_W(IDX_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (vld_ch[g]),
            .i_last (last_ch[g]),
            .i_idx  (idx_ch[g]),
            .i_data (data_ch[g]),
            .o_vld  (vld_ch[g+1]),
            .o_last (last_ch[g+1]),
            .o_idx  (idx_ch[g+1]),
            .o_data (data_ch[g+1])
        );
    end

    rrt_div u_div_c (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_neg  (r_pc < r_mc),
        .i_mag  (PROD_W'(r_max_step) * PROD_W'(magc)),
        .i_den  (r_best),
        .o_done (div_done_c),
        .o_quo  (quo_c)
    );

    rrt_div u_div_r (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_neg  (r_pr < r_mr),
        .i_mag  (PROD_W'(r_max_step) * PROD_W'(magr)),
        .i_den  (r_best),
        .o_done (div_done_r),
        .o_quo  (quo_r)
    );

    always_comb begin
        rd_col   = ram_rdata[2*CW-1:CW];
        rd_row   = ram_rdata[CW-1:0];
        dc       = $signed({1'b0, r_pc}) - $signed({1'b0, rd_col});
        dr       = $signed({1'b0, r_pr}) - $signed({1'b0, rd_row});
        sqc      = SQ_RAD_W'(dc * dc);
        sqr      = SQ_RAD_W'(dr * dr);
        iss_last = (CNT_W'(r_addr) + CNT_W'(1)) == r_cnt;
        magc     = (r_pc >= r_mc) ? (r_pc - r_mc) : (r_mc - r_pc);
        magr     = (r_pr >= r_mr) ? (r_pr - r_mr) : (r_mr - r_pr);
        nc_sum   = QW'(r_mc) + QW'(quo_c);
        nr_sum   = QW'(r_mr) + QW'(quo_r);
        in_box   = r_nc >= r_obs_l && r_nc <= r_obs_r && r_nr >= r_obs_t && r_nr <= r_obs_b;
        sweep    = f_span(r_mc, r_nc, r_obs_l, r_obs_r) && f_span(r_mr, r_nr, r_obs_t, r_obs_b);
        legal    = !r_dup && !in_box && !sweep;
        full     = r_cnt == CNT_W'(MAX_NODES);
        g_lo_c   = $signed(QW'(r_goal_c)) - $signed(QW'(r_goal_rad));
        g_hi_c   = $signed(QW'(r_goal_c)) + $signed(QW'(r_goal_rad));
        g_lo_r   = $signed(QW'(r_goal_r)) - $signed(QW'(r_goal_rad));
        g_hi_r   = $signed(QW'(r_goal_r)) + $signed(QW'(r_goal_rad));
        if (r_state == S_EXEC) begin
            sc = $signed(QW'(r_pc));
            sr = $signed(QW'(r_pr));
        end else begin
            sc = $signed(QW'(r_nc));
            sr = $signed(QW'(r_nr));
        end
        goal_hit = sc >= g_lo_c && sc <= g_hi_c && sr >= g_lo_r && sr <= g_hi_r;

        ram_we    = (r_state == S_EXEC && r_op == OP_ROOT) ||
                    (r_state == S_CHECK && legal && !full);
        ram_waddr = (r_state == S_EXEC) ? '0 : r_cnt[IDX_W-1:0];
        ram_wdata = (r_state == S_EXEC) ? {r_pc, r_pr} : {r_nc, r_nr};
        ram_raddr = (r_state == S_FETCH) ? r_near : r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_iss_vld  <= 1'b0;
            r_c_vld    <= 1'b0;
            r_div_go   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_obs_l    <= '0;
            r_obs_t    <= '0;
            r_obs_r    <= '0;
            r_obs_b    <= '0;
            r_goal_c   <= CW'(99);
            r_goal_r   <= CW'(99);
            r_goal_rad <= '0;
            r_max_step <= CW'(50);
        end else begin
            r_iss_vld <= (r_state == S_SCAN || r_state == S_DUP);
            r_div_go  <= (r_state == S_STEER) && ({1'b0, r_max_step} < r_best);
            r_out_vld <= (r_out_vld && i_out_stall) ||
                         (r_state == S_DONE && (!r_out_vld || !i_out_stall));
            r_c_vld   <= r_iss_vld && (r_state == S_SCAN || r_state == S_SCAN_WAIT);
            r_c_last  <= r_iss_last;
            r_c_idx   <= r_iss_idx;
            r_c_data  <= '{rem: '0, root: '0, rad: sqc + sqr};

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OBS_LEFT:   r_obs_l    <= i_cfg_data;
                    CFG_OBS_TOP:    r_obs_t    <= i_cfg_data;
                    CFG_OBS_RIGHT:  r_obs_r    <= i_cfg_data;
                    CFG_OBS_BOTTOM: r_obs_b    <= i_cfg_data;
                    CFG_GOAL_COL:   r_goal_c   <= i_cfg_data;
                    CFG_GOAL_ROW:   r_goal_r   <= i_cfg_data;
                    CFG_GOAL_RAD:   r_goal_rad <= i_cfg_data;
                    CFG_MAX_STEP:   r_max_step <= i_cfg_data;
                    default:        ;
                endcase
            end

            if (vld_ch[SQ_STAGES]) begin
                if (idx_ch[SQ_STAGES] == '0 || data_ch[SQ_STAGES].root < r_best) begin
                    r_best <= data_ch[SQ_STAGES].root;
                    r_near <= idx_ch[SQ_STAGES];
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.opcode;
                        r_pc    <= i_in_data.point_col;
                        r_pr    <= i_in_data.point_row;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_ROOT) begin
                        r_cnt   <= CNT_W'(1);
                        r_res   <= '{status: ST_ROOT, node_index: '0, new_col: r_pc,
                                     new_row: r_pr, parent_index: '0,
                                     reached_goal: goal_hit};
                        r_state <= S_DONE;
                    end else if (r_cnt == '0) begin
                        r_res   <= '{status: ST_EMPTY, node_index: '0, new_col: '0,
                                     new_row: '0, parent_index: '0, reached_goal: 1'b0};
                        r_state <= S_DONE;
                    end else begin
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN, S_DUP: begin
                    r_iss_last <= iss_last;
                    r_iss_idx  <= r_addr;
                    r_addr     <= r_addr + 1'b1;
                    if (iss_last) begin
                        r_state <= (r_state == S_SCAN) ? S_SCAN_WAIT : S_DUP_WAIT;
                    end
                end
                S_SCAN_WAIT: begin
                    if (vld_ch[SQ_STAGES] && last_ch[SQ_STAGES]) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_STEER;
                end
                S_STEER: begin
                    r_mc   <= rd_col;
                    r_mr   <= rd_row;
                    r_dup  <= 1'b0;
                    r_addr <= '0;
                    if ({1'b0, r_max_step} < r_best) begin
                        r_state  <= S_DIV;
                    end else begin
                        r_nc    <= r_pc;
                        r_nr    <= r_pr;
                        r_state <= S_DUP;
                    end
                end
                S_DIV: begin
                    if (div_done_c && div_done_r) begin
                        r_nc    <= nc_sum[CW-1:0];
                        r_nr    <= nr_sum[CW-1:0];
                        r_state <= S_DUP;
                    end
                end
                S_DUP_WAIT: begin
                    if (r_iss_last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!legal) begin
                        r_res <= '{status: ST_ILLEGAL, node_index: '0, new_col: r_nc,
                                   new_row: r_nr, parent_index: CW'(r_near),
                                   reached_goal: 1'b0};
                    end else if (full) begin
                        r_res <= '{status: ST_FULL, node_index: '0, new_col: r_nc,
                                   new_row: r_nr, parent_index: CW'(r_near),
                                   reached_goal: 1'b0};
                    end else begin
                        r_res <= '{status: ST_ADDED, node_index: CW'(r_cnt), new_col: r_nc,
                                   new_row: r_nr, parent_index: CW'(r_near),
                                   reached_goal: goal_hit};
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out     <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (r_iss_vld && (r_state == S_DUP || r_state == S_DUP_WAIT)) begin
                if (rd_col == r_nc && rd_row == r_nr) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_NODES))
        else $error("node count beyond store depth");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_CHECK) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("store write without count advance");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_vld || !i_out_stall)) |=> r_out_vld)
        else $error("finished transaction not presented");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_ROOT)
        else $error("status code out of range");

endmodule

[sv/rrt_ram.sv]
// generic single write port ram with registered read
module rrt_ram #(
    parameter int W     = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rrt_sqrt_cell.sv]
// one root bit of the pipelined integer square root chain
module rrt_sqrt_cell import rrt_pkg::*; #(
    parameter int IDX_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic             i_last,
    input  logic [IDX_W-1:0] i_idx,
    input  t_sq_data         i_data,
    output logic             o_vld,
    output logic             o_last,
    output logic [IDX_W-1:0] o_idx,
    output t_sq_data         o_data
);

    logic             r_vld;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;
    t_sq_data         r_data;
    t_sq_data         n_data;
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;

    always_comb begin
        cur   = {i_data.rem[SQ_REM_W-3:0], i_data.rad[SQ_RAD_W-1 -: 2]};
        trial = {1'b0, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[SQ_RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            n_data.rem  = cur - trial;
            n_data.root = {i_data.root[SQ_ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = cur;
            n_data.root = {i_data.root[SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_last <= i_last;
        r_idx  <= i_idx;
        r_data <= n_data;
    end

    assign o_vld  = r_vld;
    assign o_last = r_last;
    assign o_idx  = r_idx;
    assign o_data = r_data;

endmodule

[sv/rrt_div.sv]
// bit serial signed floor divider for the steering step
module rrt_div import rrt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_neg,
    input  logic [PROD_W-1:0]    i_mag,
    input  logic [SQ_ROOT_W-1:0] i_den,
    output logic                 o_done,
    output logic signed [QW-1:0] o_quo
);

    localparam int CNT_W = $clog2(PROD_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [SQ_ROOT_W-1:0] r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [SQ_ROOT_W-1:0] r_den;
    logic                 r_neg;
    logic [SQ_ROOT_W:0]   t;
    logic [SQ_ROOT_W:0]   t_sub;
    logic                 ge;
    logic [QW-1:0]        qm;

    always_comb begin
        t     = {r_rem, r_quo[PROD_W-1]};
        t_sub = t - {1'b0, r_den};
        ge    = t >= {1'b0, r_den};
        qm    = QW'(r_quo[CW:0]);
        if (r_neg) begin
            o_quo = $signed(-(qm + QW'(r_rem != '0)));
        end else begin
            o_quo = $signed(qm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_mag;
                r_den  <= i_den;
                r_neg  <= i_neg;
            end else if (r_busy) begin
                r_rem <= ge ? t_sub[SQ_ROOT_W-1:0] : t[SQ_ROOT_W-1:0];
                r_quo <= {r_quo[PROD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule
